@@ hw/rtl/sha512_pkg.sv @@
package sha512_pkg;

	typedef logic [63:0] word_t;

	localparam int unsigned ROUNDS = 80;
	localparam logic [6:0] LAST_ROUND = 7'd79;
	localparam logic [3:0] FULL_BYTES = 4'd8;

	function automatic word_t iv_word(input logic [2:0] i);
		word_t r;
		case (i)
			3'd0: r = 64'h6a09e667f3bcc908;
			3'd1: r = 64'hbb67ae8584caa73b;
			3'd2: r = 64'h3c6ef372fe94f82b;
			3'd3: r = 64'ha54ff53a5f1d36f1;
			3'd4: r = 64'h510e527fade682d1;
			3'd5: r = 64'h9b05688c2b3e6c1f;
			3'd6: r = 64'h1f83d9abfb41bd6b;
			default: r = 64'h5be0cd19137e2179;
		endcase
		return r;
	endfunction

	function automatic word_t round_k(input logic [6:0] r);
		word_t k;
		case (r)
			7'd0: k = 64'h428a2f98d728ae22; 7'd1: k = 64'h7137449123ef65cd;
			7'd2: k = 64'hb5c0fbcfec4d3b2f; 7'd3: k = 64'he9b5dba58189dbbc;
			7'd4: k = 64'h3956c25bf348b538; 7'd5: k = 64'h59f111f1b605d019;
			7'd6: k = 64'h923f82a4af194f9b; 7'd7: k = 64'hab1c5ed5da6d8118;
			7'd8: k = 64'hd807aa98a3030242; 7'd9: k = 64'h12835b0145706fbe;
			7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
			7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
			7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
			7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
			7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
			7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
			7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
			7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
			7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
			7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
			7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
			7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
			7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
			7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
			7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
			7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
			7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
			7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
			7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
			7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
			7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
			7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
			7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
			7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
			7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
			7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
			7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
			7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
			7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
			7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
			7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
			7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
			7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
			7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
			7'd78: k = 64'h5fcb6fab3ad6faec; default: k = 64'h6c44198c4a475817;
		endcase
		return k;
	endfunction

	function automatic word_t ror64(input word_t x, input int unsigned s);
		return (x >> s) | (x << (64 - s));
	endfunction

	typedef struct packed {
		logic  start;
		logic  busy;
		logic  done;
	} core_ctl_t;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_PAD   = 7'b0000010,
		ST_HASH  = 7'b0000100,
		ST_LEN   = 7'b0001000,
		ST_FINAL = 7'b0010000,
		ST_OUT   = 7'b0100000,
		ST_CLR   = 7'b1000000
	} state_t;

endpackage

@@ hw/rtl/sha512_if.sv @@
interface sha512_in_if;
	logic                valid;
	logic                ready;
	sha512_pkg::word_t   data_word;
	logic [3:0]          byte_count;
	logic                is_last;
	modport source (output valid, data_word, byte_count, is_last, input ready);
	modport sink (input valid, data_word, byte_count, is_last, output ready);
endinterface

interface sha512_out_if;
	logic                valid;
	logic                ready;
	sha512_pkg::word_t   digest_word;
	logic [2:0]          word_index;
	logic                last_word;
	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ hw/rtl/sha512_message_hasher_unit.sv @@
// sha-512 message hasher
// in: one word per item, data_word big-endian, byte_count used only with is_last
// out: eight digest words h0..h7 after each last word, word_index 0..7,
//   last_word on h7
// a full 128-byte block stalls input while the core loads it, runs its 80
//   rounds and the chain is updated; no word is taken meanwhile
// a non-final word that completes no block is taken without stalling input
// a last word is followed by padding and length writes, one or two
//   compressions, output of the eight digest words and a restart,
//   with output held while the receiver stalls
// reset (arst_n low) restores the initial hash values and empties the block;
//   the block buffer memory is not cleared since padding rewrites every word
// output is held while ready is low; no input is taken until h7 is delivered
module sha512_message_hasher_unit (
	input  logic                clk,
	input  logic                arst_n,
	sha512_in_if.sink           in_ch,
	sha512_out_if.source        out_ch
);
	sha512_pkg::state_t state_q;
	sha512_pkg::word_t  chain_q [8];
	sha512_pkg::word_t  vars [8];
	logic [6:0]         fill_q;
	logic [127:0]       len_q;
	logic               extra_q;
	logic [2:0]         oidx_q;
	logic [63:0]        part_q;
	logic               after_q;
	sha512_pkg::core_ctl_t cin, cout;
	logic               wr_en;
	logic [3:0]         wr_addr;
	sha512_pkg::word_t  wr_data;
	logic [3:0]         cnt;
	logic [63:0]        mask, padded;
	logic               acc;
	logic [127:0]       bits;

	assign acc = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == sha512_pkg::ST_IDLE);
	assign cnt = !in_ch.is_last ? sha512_pkg::FULL_BYTES :
		(in_ch.byte_count > 4'd8 ? sha512_pkg::FULL_BYTES : in_ch.byte_count);
	assign mask = (cnt == 4'd0) ? 64'd0 : ~(64'hffffffffffffffff >> {cnt, 3'b000});
	assign padded = (in_ch.data_word & mask) | ((cnt == 4'd8) ? 64'd0
		: (64'h8000000000000000 >> {cnt, 3'b000}));
	assign bits = {len_q[124:0], 3'b000};

	always_comb begin
		wr_en = 1'b0;
		wr_addr = fill_q[6:3];
		wr_data = '0;
		case (state_q)
			sha512_pkg::ST_IDLE: begin
				wr_en = acc;
				wr_data = in_ch.is_last ? padded : in_ch.data_word;
			end
			sha512_pkg::ST_PAD: begin
				wr_en = 1'b1;
				wr_data = part_q;
			end
			sha512_pkg::ST_LEN: begin
				wr_en = 1'b1;
				wr_addr = fill_q[3:0];
				wr_data = fill_q[0] ? bits[63:0] : bits[127:64];
			end
			default: ;
		endcase
	end

	assign cin.start = (state_q == sha512_pkg::ST_HASH) && !cout.busy && !cout.done
		&& !after_q;
	assign cin.busy = 1'b0;
	assign cin.done = 1'b0;

	sha512_core u_core (
		.clk(clk), .arst_n(arst_n), .ctl_in(cin), .ctl_out(cout),
		.wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
		.chain_in(chain_q), .vars_out(vars)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha512_pkg::ST_IDLE;
			for (int i = 0; i < 8; i++) chain_q[i] <= sha512_pkg::iv_word(3'(i));
			fill_q <= '0;
			len_q <= '0;
			extra_q <= 1'b0;
			oidx_q <= '0;
			part_q <= '0;
			after_q <= 1'b0;
		end else begin
			case (state_q)
				sha512_pkg::ST_IDLE: begin
					if (acc) begin
						len_q <= len_q + 128'(cnt);
						if (!in_ch.is_last) begin
							fill_q <= fill_q + 7'd8;
							if (fill_q[6:3] == 4'd15) begin
								state_q <= sha512_pkg::ST_HASH;
								after_q <= 1'b0;
								extra_q <= 1'b0;
							end
						end else begin
							// tail already written, with the marker unless the word is full (part_q holds it then); zero fill to length slot
							part_q <= (cnt == 4'd8) ? 64'h8000000000000000 : 64'd0;
							extra_q <= 1'b1;
							if (fill_q[6:3] == 4'd15) begin
								// block is full, padding goes to a block of its own
								fill_q <= '0;
								state_q <= sha512_pkg::ST_HASH;
								after_q <= 1'b0;
							end else begin
								fill_q <= {fill_q[6:3] + 4'd1, 3'b000};
								state_q <= sha512_pkg::ST_PAD;
							end
						end
					end
				end
				sha512_pkg::ST_PAD: begin
					part_q <= '0;
					fill_q <= {fill_q[6:3] + 4'd1, 3'b000};
					if (fill_q[6:3] == 4'd13
							|| (fill_q[6:3] == 4'd14 && part_q == 64'd0)) begin
						fill_q <= 7'd14;
						state_q <= sha512_pkg::ST_LEN;
					end else if (fill_q[6:3] == 4'd15) begin
						state_q <= sha512_pkg::ST_HASH;
						after_q <= 1'b0;
					end
				end
				sha512_pkg::ST_LEN: begin
					fill_q <= fill_q + 7'd1;
					if (fill_q[0]) begin
						extra_q <= 1'b0;
						state_q <= sha512_pkg::ST_FINAL;
					end
				end
				sha512_pkg::ST_FINAL: begin
					state_q <= sha512_pkg::ST_HASH;
					after_q <= 1'b0;
				end
				sha512_pkg::ST_HASH: begin
					if (cin.start) begin
						after_q <= 1'b1;
					end
					if (cout.done) begin
						for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + vars[i];
						after_q <= 1'b0;
						fill_q <= '0;
						if (extra_q) begin
							state_q <= sha512_pkg::ST_PAD;
						end else if (fill_q == 7'd16) begin
							state_q <= sha512_pkg::ST_OUT;
						end else begin
							state_q <= sha512_pkg::ST_IDLE;
						end
					end
				end
				sha512_pkg::ST_OUT: begin
					if (out_ch.ready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							state_q <= sha512_pkg::ST_CLR;
						end
					end
				end
				sha512_pkg::ST_CLR: begin
					for (int i = 0; i < 8; i++) chain_q[i] <= sha512_pkg::iv_word(3'(i));
					fill_q <= '0;
					len_q <= '0;
					state_q <= sha512_pkg::ST_IDLE;
				end
				default: state_q <= sha512_pkg::ST_IDLE;
			endcase
		end
	end

	assign out_ch.valid = (state_q == sha512_pkg::ST_OUT);
	assign out_ch.digest_word = chain_q[oidx_q];
	assign out_ch.word_index = oidx_q;
	assign out_ch.last_word = (oidx_q == 3'd7);

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !cout.busy)
		else $error("input taken while rounds run");
	a_out_no_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !cout.busy && !in_ch.ready)
		else $error("output while hashing");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cout.done |-> $past(cout.busy))
		else $error("done without rounds");
	a_idx_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> oidx_q == 3'd0)
		else $error("digest index not reset");
endmodule

@@ hw/rtl/sha512_core.sv @@
// 80-round compression; schedule kept in a 16-entry memory, one round per cycle
module sha512_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sha512_pkg::core_ctl_t ctl_in,
	output sha512_pkg::core_ctl_t ctl_out,
	input  logic                  wr_en,
	input  logic [3:0]            wr_addr,
	input  sha512_pkg::word_t     wr_data,
	input  sha512_pkg::word_t     chain_in [8],
	output sha512_pkg::word_t     vars_out [8]
);
	sha512_pkg::word_t sched_mem [16];
	sha512_pkg::word_t v_q [8];
	sha512_pkg::word_t w_q [16];
	logic [6:0] rnd_q;
	logic       busy_q;
	logic       done_q;
	sha512_pkg::word_t wv, x15, x2, s0, s1, big0, big1, chs, mj, t1, t2;
	logic [3:0] ri;

	assign ri = rnd_q[3:0];

	// block memory: written by the hasher, copied into the working schedule at start
	always_ff @(posedge clk) begin
		if (wr_en) begin
			sched_mem[wr_addr] <= wr_data;
		end
	end

	always_comb begin
		x15 = w_q[ri + 4'd1];
		x2 = w_q[ri + 4'd14];
		s0 = sha512_pkg::ror64(x15, 1) ^ sha512_pkg::ror64(x15, 8) ^ (x15 >> 7);
		s1 = sha512_pkg::ror64(x2, 19) ^ sha512_pkg::ror64(x2, 61) ^ (x2 >> 6);
		if (rnd_q < 7'd16) begin
			wv = w_q[ri];
		end else begin
			wv = w_q[ri] + s0 + w_q[ri + 4'd9] + s1;
		end
		big1 = sha512_pkg::ror64(v_q[4], 14) ^ sha512_pkg::ror64(v_q[4], 18)
			^ sha512_pkg::ror64(v_q[4], 41);
		chs = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1 = v_q[7] + big1 + chs + sha512_pkg::round_k(rnd_q) + wv;
		big0 = sha512_pkg::ror64(v_q[0], 28) ^ sha512_pkg::ror64(v_q[0], 34)
			^ sha512_pkg::ror64(v_q[0], 39);
		mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2 = big0 + mj;
	end

	always_ff @(posedge clk) begin
		if (ctl_in.start) begin
			for (int i = 0; i < 16; i++) w_q[i] <= sched_mem[i];
			for (int i = 0; i < 8; i++) v_q[i] <= chain_in[i];
		end else if (busy_q) begin
			w_q[ri] <= wv;
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl_in.start) begin
				busy_q <= 1'b1;
				rnd_q <= '0;
			end else if (busy_q) begin
				if (rnd_q == sha512_pkg::LAST_ROUND) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					rnd_q <= '0;
				end else begin
					rnd_q <= rnd_q + 7'd1;
				end
			end
		end
	end

	assign vars_out = v_q;
	assign ctl_out.start = 1'b0;
	assign ctl_out.busy = busy_q;
	assign ctl_out.done = done_q;
endmodule

@@ verif/sha512_message_hasher_unit_tb.sv @@
module sha512_message_hasher_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef sha512_pkg::word_t word_t;

	typedef struct {
		word_t      data_word;
		logic [3:0] byte_count;
		logic       is_last;
	} msg_word_t;

	typedef struct {
		word_t      digest_word;
		logic [2:0] word_index;
		logic       last_word;
	} digest_t;

	localparam word_t SHA_IV [8] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
		64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
		64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

	localparam word_t SHA_K [80] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;

	sha512_in_if  in_ch();
	sha512_out_if out_ch();

	sha512_message_hasher_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// hashing state of the predictor
	word_t       chain [8];
	word_t       blk [16];
	int unsigned blk_fill;
	logic [127:0] msg_len;

	msg_word_t pending_words[$];
	digest_t   digest_q[$];

	int unsigned words_sent;
	int unsigned digests_seen;
	int unsigned messages_done;
	int unsigned mismatches;
	int unsigned cycle_cnt;
	int unsigned in_wait;
	int unsigned out_wait;
	int unsigned hold_cycles;
	bit          hold_done;
	bit          stim_done;

	function automatic word_t rotr(word_t x, int unsigned s);
		return (x >> s) | (x << (64 - s));
	endfunction

	function automatic void hash_reset();
		for (int i = 0; i < 8; i++)
			chain[i] = SHA_IV[i];
		for (int i = 0; i < 16; i++)
			blk[i] = '0;
		blk_fill = 0;
		msg_len = '0;
	endfunction

	function automatic void compress();
		word_t w [16];
		word_t v [8];
		word_t wv, x15, x2, t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = blk[i];
		for (int i = 0; i < 8; i++)
			v[i] = chain[i];
		for (int r = 0; r < 80; r++) begin
			if (r < 16) begin
				wv = w[r];
			end else begin
				x15 = w[(r + 1) & 15];
				x2 = w[(r + 14) & 15];
				wv = w[r & 15] + (rotr(x15, 1) ^ rotr(x15, 8) ^ (x15 >> 7)) + w[(r + 9) & 15]
					+ (rotr(x2, 19) ^ rotr(x2, 61) ^ (x2 >> 6));
				w[r & 15] = wv;
			end
			t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[r] + wv;
			t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain[i] += v[i];
	endfunction

	function automatic void push_byte(logic [7:0] b);
		blk[blk_fill >> 3][63 - 8 * (blk_fill & 7) -: 8] = b;
		blk_fill++;
		if (blk_fill == 128) begin
			compress();
			blk_fill = 0;
		end
	endfunction

	function automatic void absorb_word(msg_word_t m);
		int unsigned n;
		logic [127:0] bits;
		digest_t d;
		n = 8;
		if (m.is_last)
			n = (m.byte_count > 8) ? 8 : m.byte_count;
		for (int i = 0; i < n; i++)
			push_byte(m.data_word[63 - 8 * i -: 8]);
		msg_len += n;
		if (m.is_last) begin
			bits = msg_len << 3;
			push_byte(8'h80);
			while (blk_fill != 112)
				push_byte(8'h00);
			blk[14] = bits[127:64];
			blk[15] = bits[63:0];
			compress();
			for (int i = 0; i < 8; i++) begin
				d.digest_word = chain[i];
				d.word_index = i;
				d.last_word = (i == 7);
				digest_q.push_back(d);
			end
			hash_reset();
		end
	endfunction

	function automatic void add_word(word_t data, logic [3:0] cnt, logic last);
		msg_word_t m;
		m.data_word = data;
		m.byte_count = cnt;
		m.is_last = last;
		pending_words.push_back(m);
	endfunction

	function automatic word_t rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic void add_message(int unsigned n_full);
		for (int i = 0; i < n_full; i++)
			add_word(rand_word(), $urandom_range(0, 15), 1'b0);
		add_word(rand_word(), $urandom_range(0, 15), 1'b1);
	endfunction

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data_word <= '0;
			in_ch.byte_count <= '0;
			in_ch.is_last <= 1'b0;
			in_wait <= 0;
		end else if (in_ch.valid && !in_ch.ready) begin
			// hold the offered word
		end else begin
			if (in_ch.valid) begin
				absorb_word('{in_ch.data_word, in_ch.byte_count, in_ch.is_last});
				words_sent <= words_sent + 1;
			end
			if (in_wait != 0) begin
				in_ch.valid <= 1'b0;
				in_wait <= in_wait - 1;
			end else if (pending_words.size() != 0) begin
				in_ch.valid <= 1'b1;
				in_ch.data_word <= pending_words[0].data_word;
				in_ch.byte_count <= pending_words[0].byte_count;
				in_ch.is_last <= pending_words[0].is_last;
				void'(pending_words.pop_front());
				in_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			out_wait <= 0;
			hold_cycles <= 0;
			hold_done <= 1'b0;
		end else if (hold_cycles != 0) begin
			out_ch.ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else if (!hold_done && words_sent >= 60) begin
			hold_cycles <= 3000;
			hold_done <= 1'b1;
			out_ch.ready <= 1'b0;
		end else if (out_wait != 0) begin
			out_ch.ready <= 1'b0;
			out_wait <= out_wait - 1;
		end else if (out_ch.ready && out_ch.valid) begin
			out_ch.ready <= 1'b0;
			out_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		digest_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			digests_seen <= digests_seen + 1;
			if (digest_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected digest word %h idx %0d", out_ch.digest_word,
						out_ch.word_index);
			end else begin
				e = digest_q.pop_front();
				if (e.last_word)
					messages_done <= messages_done + 1;
				if (out_ch.digest_word !== e.digest_word || out_ch.word_index !== e.word_index
						|| out_ch.last_word !== e.last_word) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h/%0d/%0b got %h/%0d/%0b",
							e.digest_word, e.word_index, e.last_word, out_ch.digest_word,
							out_ch.word_index, out_ch.last_word);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned total;
		arst_n = 1'b0;
		words_sent = 0;
		digests_seen = 0;
		messages_done = 0;
		mismatches = 0;
		cycle_cnt = 0;
		stim_done = 0;
		hash_reset();

		// empty message, zero-count and oversize counts, single bytes
		add_word(64'h0, 4'd0, 1'b1);
		add_word(64'h6162630000000000, 4'd3, 1'b1);
		add_word(64'hffffffffffffffff, 4'd15, 1'b1);
		add_word(64'hffffffffffffffff, 4'd8, 1'b1);
		add_word(64'h8000000000000000, 4'd1, 1'b1);
		add_word(64'hffffffffffffffff, 4'd9, 1'b0);
		add_word(64'h0, 4'd0, 1'b0);
		add_word(64'h0123456789abcdef, 4'd7, 1'b1);
		// 14 words: 112 bytes forces the extra padding block
		for (int i = 0; i < 14; i++)
			add_word(rand_word(), 4'd0, 1'b0);
		add_word(64'hffffffffffffffff, 4'd0, 1'b1);
		// 111 bytes fits in one block
		for (int i = 0; i < 13; i++)
			add_word(rand_word(), 4'd8, 1'b0);
		add_word(rand_word(), 4'd7, 1'b1);
		// last word fills the block, padding goes to a block of its own
		for (int i = 0; i < 15; i++)
			add_word(rand_word(), 4'd8, 1'b0);
		add_word(rand_word(), 4'd8, 1'b1);
		// exactly one full block then a last word of random byte count
		add_message(16);
		total = pending_words.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (total < 220) begin
			int unsigned n;
			n = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 34) : $urandom_range(0, 6);
			add_message(n);
			total += n + 1;
		end

		wait (pending_words.size() == 0 && !in_ch.valid);
		wait (digest_q.size() == 0);
		repeat (200) @(posedge clk);
		$display("sent %0d message words, checked %0d digests (%0d digest words)",
			words_sent, messages_done, digests_seen);
		$display("covered empty, partial, oversize-count and multi-block messages");
		if (mismatches == 0 && digest_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
